FILE: hdl/kea_pkg.sv
// ----------------------------------------------------------------------------
// kea_pkg
// Shared constants, command codes, status struct and arc tables for the
// Kepler equation solver.
// ----------------------------------------------------------------------------
`default_nettype none

package kea_pkg;

  localparam int CORDIC_STAGES  = 28;
  localparam int MAX_ITER_LIMIT = 64;

  localparam int ITER_W     = 7;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam int ECC_W      = 28;
  localparam int Q_W        = 32;
  localparam int CORDIC_W   = 36;
  localparam int ST_W       = $clog2(CORDIC_STAGES + 1);
  localparam int DIV_BITS   = 56;
  localparam int DCNT_W     = $clog2(DIV_BITS + 1);

  localparam logic [CFG_ADDR_W-1:0] CFG_REL_TOL    = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ITER_LIMIT = 1'b1;

  localparam logic [31:0]        REL_TOL_RESET    = 32'd4096;
  localparam logic [ITER_W-1:0]  ITER_LIMIT_RESET = 7'd16;

  // Q24 constants
  localparam logic [31:0] ONE_Q24      = 32'd16777216;
  localparam logic [31:0] PI_Q24       = 32'd52707179;
  localparam logic [31:0] TWO_PI_Q24   = 32'd105414358;
  localparam logic [31:0] LN2_Q24      = 32'd11629080;
  localparam logic [31:0] HALF_LN2_Q24 = 32'd5814540;
  localparam logic [31:0] HYP_ARG_MAX  = 32'd134217728;

  // Q30 constants
  localparam logic signed [CORDIC_W-1:0] PI_Q30        = 36'sd3373259426;
  localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30   = 36'sd1686629713;
  localparam logic signed [CORDIC_W-1:0] CIRC_GAIN_Q30 = 36'sd652032874;
  localparam logic signed [CORDIC_W-1:0] HYP_GAIN_Q30  = 36'sd1296540104;
  localparam logic [31:0]                QUARTER_PI_Q30 = 32'd843314857;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_EST_M,
    CMD_TOLMUL,
    CMD_TOLSAVE,
    CMD_ANG_EST,
    CMD_MOD_STEP,
    CMD_CORDIC_INIT,
    CMD_CORDIC_STEP,
    CMD_POST1,
    CMD_POST2,
    CMD_MUL_S,
    CMD_MUL_C,
    CMD_NUM,
    CMD_DEN,
    CMD_MEST,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_UPDATE,
    CMD_WRAP_FIN,
    CMD_OUT
  } dp_cmd_t;

  typedef struct packed {
    logic red_done;
    logic cordic_done;
    logic div_done;
    logic e_zero;
    logic ell;
    logic conv;
  } dp_status_t;

  typedef logic [CORDIC_STAGES:0][31:0] arc_tab_t;

  // atan(2^-i) or atanh(2^-i) in Q30, series summed in Q62
  function automatic arc_tab_t build_arc(input logic hyp);
    arc_tab_t    tab;
    logic [63:0] acc;
    logic [63:0] t;
    logic [63:0] rnd;
    int unsigned sh;
    int unsigned dv;
    for (int i = 0; i <= CORDIC_STAGES; i++) begin
      acc = '0;
      for (int k = 0; k < 64; k++) begin
        sh = i * (2 * k + 1);
        dv = 2 * k + 1;
        if (sh <= 62) begin
          t = (64'h4000_0000_0000_0000 >> sh) / 64'(dv);
          if (hyp || ((k & 1) == 0)) acc = acc + t;
          else acc = acc - t;
        end
      end
      rnd = (acc + 64'h0000_0000_8000_0000) >> 32;
      if (!hyp && i == 0) tab[i] = QUARTER_PI_Q30;
      else tab[i] = rnd[31:0];
    end
    return tab;
  endfunction

  localparam arc_tab_t ATAN_TAB  = build_arc(1'b0);
  localparam arc_tab_t ATANH_TAB = build_arc(1'b1);

endpackage

`default_nettype wire

FILE: hdl/kea_dp.sv
// ----------------------------------------------------------------------------
// kea_dp
// Datapath: range reduction, shared circular/hyperbolic CORDIC, multiplier,
// bit-serial divider, Newton update and convergence compare.
// ----------------------------------------------------------------------------
`default_nettype none

module kea_dp import kea_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dp_cmd_t               cmd,
  input  wire logic [ECC_W-1:0]      ecc_in,
  input  wire logic signed [Q_W-1:0] m_in,
  input  wire logic signed [Q_W-1:0] est_in,
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output dp_status_t                 status,
  output logic signed [Q_W-1:0]      out_est,
  output logic                       out_ov
);

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = 32'sh7FFF_FFFF;
    else if (v < SAT_MIN) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic sat_hit(input logic signed [63:0] v);
    return (v > SAT_MAX) || (v < SAT_MIN);
  endfunction

  logic [31:0]                tol_r;
  logic [63:0]                tolprod_r;
  logic [ECC_W-1:0]           e_r;
  logic signed [Q_W-1:0]      m_r, est_r;
  logic [31:0]                absm_r;
  logic                       ell_r, ov_r, neg_r, fold_r;
  logic [31:0]                ang_r;
  logic [3:0]                 q_r;
  logic signed [CORDIC_W-1:0] x_r, y_r, z_r;
  logic [ST_W-1:0]            st_r, hi_r;
  logic [6:0]                 rep_r;
  logic                       again_r;
  logic signed [49:0]         p_r, n_r;
  logic signed [Q_W-1:0]      s_r, c_r;
  logic signed [65:0]         prod_r;
  logic signed [Q_W-1:0]      num_r, den_r, mest_r;
  logic [31:0]                rem_r, ad_r;
  logic [DIV_BITS-1:0]        quo_r, dvd_r;
  logic [DCNT_W-1:0]          dcnt_r;
  logic                       dsign_r;
  logic signed [Q_W-1:0]      out_est_r;
  logic                       out_ov_r;

  // multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  always_comb begin
    if (cmd == CMD_TOLMUL) begin
      mul_a = $signed({1'b0, tol_r});
      mul_b = $signed({1'b0, absm_r});
    end else begin
      mul_a = $signed({5'b0, e_r});
      mul_b = (cmd == CMD_MUL_C) ? 33'(c_r) : 33'(s_r);
    end
  end
  assign mul_p = mul_a * mul_b;

  // e*x in Q24, saturated
  logic signed [63:0] mq;
  logic signed [31:0] sm;
  logic               sm_ov;
  assign mq    = 64'(prod_r >>> 24);
  assign sm    = sat32(mq);
  assign sm_ov = sat_hit(mq);

  logic signed [63:0] num_t, den_t, mest_t;
  always_comb begin
    if (ell_r) begin
      num_t  = 64'(est_r) - 64'(sm) - 64'(m_r);
      den_t  = $signed(64'(ONE_Q24)) - 64'(sm);
      mest_t = 64'(est_r) - 64'(sm);
    end else begin
      num_t  = 64'(sm) - 64'(est_r) - 64'(m_r);
      den_t  = 64'(sm) - $signed(64'(ONE_Q24));
      mest_t = 64'(sm) - 64'(est_r);
    end
  end

  // argument load and reduction
  logic [31:0] abs_est, ang_ld, kred;
  assign abs_est = est_r[31] ? (~est_r + 32'd1) : est_r;
  assign ang_ld  = ell_r ? abs_est
                 : (((abs_est > HYP_ARG_MAX) ? HYP_ARG_MAX : abs_est) + HALF_LN2_Q24);
  assign kred    = ell_r ? TWO_PI_Q24 : LN2_Q24;

  // CORDIC start values
  logic signed [CORDIC_W-1:0] rr0, rr, zc, zh, zc_f;
  logic                       fold_n;
  always_comb begin
    rr0 = $signed(CORDIC_W'(ang_r));
    if (neg_r) rr0 = -rr0;
    rr = rr0;
    if (rr0 > $signed(CORDIC_W'(PI_Q24))) rr = rr0 - $signed(CORDIC_W'(TWO_PI_Q24));
    else if (rr0 < -$signed(CORDIC_W'(PI_Q24))) rr = rr0 + $signed(CORDIC_W'(TWO_PI_Q24));
    zc     = rr <<< 6;
    zc_f   = zc;
    fold_n = 1'b0;
    if (zc > HALF_PI_Q30) begin
      zc_f   = PI_Q30 - zc;
      fold_n = 1'b1;
    end else if (zc < -HALF_PI_Q30) begin
      zc_f   = -PI_Q30 - zc;
      fold_n = 1'b1;
    end
    zh = ($signed(CORDIC_W'(ang_r)) - $signed(CORDIC_W'(HALF_LN2_Q24))) <<< 6;
  end

  // one CORDIC stage
  logic [ST_W-1:0]            idx;
  logic signed [CORDIC_W-1:0] dx, dy, arc;
  assign idx = ell_r ? st_r : hi_r;
  assign dx  = y_r >>> idx;
  assign dy  = x_r >>> idx;
  assign arc = ell_r ? $signed(CORDIC_W'(ATAN_TAB[st_r]))
                     : $signed(CORDIC_W'(ATANH_TAB[hi_r]));

  // post scaling
  logic signed [CORDIC_W:0] ep, em;
  logic signed [49:0]       em_bias;
  logic signed [63:0]       sc_s, sc_c, hv_s, hv_c;
  always_comb begin
    ep      = (CORDIC_W+1)'(x_r) + (CORDIC_W+1)'(y_r);
    em      = (CORDIC_W+1)'(x_r) - (CORDIC_W+1)'(y_r);
    em_bias = em[CORDIC_W] ? ((50'sd1 <<< q_r) - 50'sd1) : 50'sd0;
    sc_s    = (64'(y_r) + 64'sd32) >>> 6;
    sc_c    = (64'(x_r) + 64'sd32) >>> 6;
    if (fold_r) sc_c = -sc_c;
    hv_s    = (64'(p_r) - 64'(n_r) + 64'sd64) >>> 7;
    hv_c    = (64'(p_r) + 64'(n_r) + 64'sd64) >>> 7;
    if (neg_r) hv_s = -hv_s;
  end

  // divider step
  logic [32:0] rem2;
  logic        ge;
  assign rem2 = {rem_r, dvd_r[DIV_BITS-1]};
  assign ge   = rem2 >= {1'b0, ad_r};

  // Newton update
  logic signed [31:0] delta;
  logic               dov;
  logic signed [63:0] est_t;
  logic [32:0]        qneg;
  always_comb begin
    qneg = -{1'b0, quo_r[31:0]};
    if (den_r == '0) begin
      delta = (num_r > 0) ? 32'sh7FFF_FFFF : ((num_r < 0) ? 32'sh8000_0000 : 32'sd0);
      dov   = (num_r != '0);
    end else if (!dsign_r) begin
      dov   = |quo_r[DIV_BITS-1:31];
      delta = dov ? 32'sh7FFF_FFFF : $signed(quo_r[31:0]);
    end else begin
      dov   = (|quo_r[DIV_BITS-1:32]) || (quo_r[31] && (|quo_r[30:0]));
      delta = dov ? 32'sh8000_0000 : $signed(qneg[31:0]);
    end
    est_t = 64'(est_r) - 64'(delta);
  end

  // convergence: |M - Mest| * 2^32 <= tol * |M|
  logic signed [63:0] dm;
  logic [63:0]        diff;
  assign dm   = 64'(m_r) - 64'(mest_r);
  assign diff = dm[63] ? 64'(-dm) : 64'(dm);

  assign status.red_done    = ang_r < kred;
  assign status.cordic_done = st_r == ST_W'(CORDIC_STAGES);
  assign status.div_done    = dcnt_r == DCNT_W'(DIV_BITS);
  assign status.e_zero      = e_r == '0;
  assign status.ell         = ell_r;
  assign status.conv        = {diff[31:0], 32'b0} <= tolprod_r;

  assign out_est = out_est_r;
  assign out_ov  = out_ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= REL_TOL_RESET;
    end else if (cfg_wen && cfg_addr == CFG_REL_TOL) begin
      tol_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        e_r    <= (ecc_in == ECC_W'(ONE_Q24)) ? ECC_W'(ONE_Q24) + ECC_W'(1) : ecc_in;
        ell_r  <= ecc_in < ECC_W'(ONE_Q24);
        m_r    <= m_in;
        est_r  <= est_in;
        absm_r <= m_in[31] ? (~m_in + 32'd1) : m_in;
        ov_r   <= 1'b0;
      end
      CMD_EST_M: est_r <= m_r;
      CMD_TOLMUL, CMD_MUL_S, CMD_MUL_C: prod_r <= mul_p;
      CMD_TOLSAVE: tolprod_r <= prod_r[63:0];
      CMD_ANG_EST: begin
        ang_r <= ang_ld;
        neg_r <= est_r[31];
        q_r   <= '0;
      end
      CMD_MOD_STEP: begin
        if (ang_r >= kred) begin
          ang_r <= ang_r - kred;
          q_r   <= q_r + 4'd1;
        end
      end
      CMD_CORDIC_INIT: begin
        st_r    <= '0;
        hi_r    <= ST_W'(1);
        rep_r   <= 7'd4;
        again_r <= 1'b0;
        y_r     <= '0;
        if (ell_r) begin
          x_r    <= CIRC_GAIN_Q30;
          z_r    <= zc_f;
          fold_r <= fold_n;
        end else begin
          x_r    <= HYP_GAIN_Q30;
          z_r    <= zh;
          fold_r <= 1'b0;
        end
      end
      CMD_CORDIC_STEP: begin
        st_r <= st_r + ST_W'(1);
        if (ell_r) begin
          if (!z_r[CORDIC_W-1]) begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - arc;
          end else begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + arc;
          end
        end else begin
          if (!z_r[CORDIC_W-1]) begin
            x_r <= x_r + dx;
            y_r <= y_r + dy;
            z_r <= z_r - arc;
          end else begin
            x_r <= x_r - dx;
            y_r <= y_r - dy;
            z_r <= z_r + arc;
          end
          // stages 4, 13, 40 ... run twice
          if (7'(hi_r) == rep_r && !again_r) begin
            again_r <= 1'b1;
          end else begin
            if (7'(hi_r) == rep_r) rep_r <= 7'(rep_r * 7'd3 + 7'd1);
            hi_r    <= hi_r + ST_W'(1);
            again_r <= 1'b0;
          end
        end
      end
      CMD_POST1: begin
        if (ell_r) begin
          s_r <= sc_s[31:0];
          c_r <= sc_c[31:0];
        end else begin
          p_r <= 50'(ep) <<< q_r;
          n_r <= (50'(em) + em_bias) >>> q_r;
        end
      end
      CMD_POST2: begin
        if (!ell_r) begin
          s_r  <= sat32(hv_s);
          c_r  <= sat32(hv_c);
          ov_r <= ov_r | sat_hit(hv_s) | sat_hit(hv_c);
        end
      end
      CMD_NUM: begin
        num_r <= sat32(num_t);
        ov_r  <= ov_r | sm_ov | sat_hit(num_t);
      end
      CMD_DEN: begin
        den_r <= sat32(den_t);
        ov_r  <= ov_r | sm_ov | sat_hit(den_t);
      end
      CMD_MEST: begin
        mest_r <= sat32(mest_t);
        ov_r   <= ov_r | sm_ov | sat_hit(mest_t);
      end
      CMD_DIV_INIT: begin
        dvd_r   <= {(num_r[31] ? (~num_r + 32'd1) : num_r), 24'b0};
        ad_r    <= den_r[31] ? (~den_r + 32'd1) : den_r;
        rem_r   <= '0;
        quo_r   <= '0;
        dcnt_r  <= '0;
        dsign_r <= num_r[31] ^ den_r[31];
      end
      CMD_DIV_STEP: begin
        rem_r  <= ge ? 32'(rem2 - {1'b0, ad_r}) : rem2[31:0];
        quo_r  <= {quo_r[DIV_BITS-2:0], ge};
        dvd_r  <= {dvd_r[DIV_BITS-2:0], 1'b0};
        dcnt_r <= dcnt_r + DCNT_W'(1);
      end
      CMD_UPDATE: begin
        est_r <= sat32(est_t);
        ov_r  <= ov_r | dov | sat_hit(est_t);
      end
      CMD_WRAP_FIN: begin
        est_r <= (neg_r && ang_r != '0) ? $signed(TWO_PI_Q24 - ang_r) : $signed(ang_r);
      end
      CMD_OUT: begin
        out_est_r <= est_r;
        out_ov_r  <= ov_r;
      end
      CMD_NOP: ;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/kea_ctrl.sv
// ----------------------------------------------------------------------------
// kea_ctrl
// Sequencer for the Newton solve: steps the datapath, counts iterations,
// owns the iteration limit and the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module kea_ctrl import kea_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [ITER_W-1:0]          out_iters,
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire dp_status_t            status,
  output dp_cmd_t                    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_START, ST_ZERO, ST_TOLMUL, ST_TOLSAVE,
    ST_ANG, ST_RED, ST_CINIT, ST_CSTEP, ST_POST1, ST_POST2,
    ST_MULS, ST_NUM, ST_MULC, ST_DEN, ST_DINIT, ST_DSTEP, ST_UPD,
    ST_MEST, ST_CHECK, ST_WANG, ST_WRED, ST_WFIN, ST_FINISH
  } state_t;

  state_t            state_r;
  logic [ITER_W-1:0] limit_r, iter_r, out_iters_r;
  logic              ph_r, conv_r, out_valid_r;

  logic [ITER_W-1:0] lim_eff, iter_nxt;
  logic              out_free;
  logic              out_valid_nxt;

  assign lim_eff  = (limit_r == '0) ? ITER_W'(1)
                  : ((limit_r > ITER_W'(MAX_ITER_LIMIT)) ? ITER_W'(MAX_ITER_LIMIT) : limit_r);
  assign iter_nxt = iter_r + ITER_W'(1);
  assign out_free = !out_valid_r || out_tready;

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_iters  = out_iters_r;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (state_r == ST_FINISH && out_free) out_valid_nxt = 1'b1;
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE:    cmd = in_tvalid ? CMD_LOAD : CMD_NOP;
      ST_ZERO:    cmd = CMD_EST_M;
      ST_TOLMUL:  cmd = CMD_TOLMUL;
      ST_TOLSAVE: cmd = CMD_TOLSAVE;
      ST_ANG:     cmd = CMD_ANG_EST;
      ST_WANG:    cmd = CMD_ANG_EST;
      ST_RED:     cmd = status.red_done ? CMD_NOP : CMD_MOD_STEP;
      ST_WRED:    cmd = status.red_done ? CMD_NOP : CMD_MOD_STEP;
      ST_CINIT:   cmd = CMD_CORDIC_INIT;
      ST_CSTEP:   cmd = status.cordic_done ? CMD_NOP : CMD_CORDIC_STEP;
      ST_POST1:   cmd = CMD_POST1;
      ST_POST2:   cmd = CMD_POST2;
      ST_MULS:    cmd = CMD_MUL_S;
      ST_NUM:     cmd = CMD_NUM;
      ST_MULC:    cmd = CMD_MUL_C;
      ST_DEN:     cmd = CMD_DEN;
      ST_DINIT:   cmd = CMD_DIV_INIT;
      ST_DSTEP:   cmd = status.div_done ? CMD_NOP : CMD_DIV_STEP;
      ST_UPD:     cmd = CMD_UPDATE;
      ST_MEST:    cmd = CMD_MEST;
      ST_WFIN:    cmd = CMD_WRAP_FIN;
      ST_FINISH:  cmd = out_free ? CMD_OUT : CMD_NOP;
      default:    cmd = CMD_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= ITER_LIMIT_RESET;
      iter_r      <= '0;
      ph_r        <= 1'b0;
      conv_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_iters_r <= '0;
    end else begin
      if (cfg_wen && cfg_addr == CFG_ITER_LIMIT) limit_r <= cfg_wdata[ITER_W-1:0];
      out_valid_r <= out_valid_nxt;

      unique case (state_r)
        ST_IDLE:  if (in_tvalid) state_r <= ST_START;
        ST_START: begin
          iter_r  <= '0;
          ph_r    <= 1'b0;
          conv_r  <= 1'b0;
          state_r <= status.e_zero ? ST_ZERO : ST_TOLMUL;
        end
        ST_ZERO: begin
          iter_r  <= ITER_W'(1);
          conv_r  <= 1'b1;
          state_r <= ST_FINISH;
        end
        ST_TOLMUL:  state_r <= ST_TOLSAVE;
        ST_TOLSAVE: state_r <= ST_ANG;
        ST_ANG:     state_r <= ST_RED;
        ST_RED:     if (status.red_done) state_r <= ST_CINIT;
        ST_CINIT:   state_r <= ST_CSTEP;
        ST_CSTEP:   if (status.cordic_done) state_r <= ST_POST1;
        ST_POST1:   state_r <= ST_POST2;
        ST_POST2:   state_r <= ST_MULS;
        ST_MULS:    state_r <= ph_r ? ST_MEST : ST_NUM;
        ST_NUM:     state_r <= ST_MULC;
        ST_MULC:    state_r <= ST_DEN;
        ST_DEN:     state_r <= ST_DINIT;
        ST_DINIT:   state_r <= ST_DSTEP;
        ST_DSTEP:   if (status.div_done) state_r <= ST_UPD;
        ST_UPD: begin
          ph_r    <= 1'b1;
          state_r <= ST_ANG;
        end
        ST_MEST:    state_r <= ST_CHECK;
        ST_CHECK: begin
          iter_r <= iter_nxt;
          conv_r <= status.conv;
          ph_r   <= 1'b0;
          if (status.conv || iter_nxt >= lim_eff) begin
            state_r <= status.ell ? ST_WANG : ST_FINISH;
          end else begin
            state_r <= ST_ANG;
          end
        end
        ST_WANG:    state_r <= ST_WRED;
        ST_WRED:    if (status.red_done) state_r <= ST_WFIN;
        ST_WFIN:    state_r <= ST_FINISH;
        ST_FINISH: begin
          if (out_free) begin
            out_iters_r <= conv_r ? iter_r : '0;
            state_r     <= ST_IDLE;
          end
        end
        default:    state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/kepler_eccentric_anomaly_solver.sv
// ----------------------------------------------------------------------------
// kepler_eccentric_anomaly_solver
// Newton solver for Kepler's equation (elliptic and hyperbolic), Q7.24.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  in_      | in  | in_tvalid/in_tready   | eccentricity, mean_anomaly, start_estimate
//  out_     | out | out_tvalid/out_tready | eccentric_anomaly, iterations_used, overflow
//  cfg_     | in  | cfg_wen               | 0: relative_tolerance, 1: iteration_limit
//
// One word at a time. Each Newton iteration runs two 28-stage CORDIC passes,
// each after an argument reduction by repeated subtraction, and a bit-serial
// divide; a full solve adds setup, a final 2*pi wrap for elliptic orbits and output.
// Zero eccentricity skips the Newton iterations and returns the mean anomaly.
// Reset is synchronous; no clearing pass. The result sits in an output
// register so a new word is taken while the last result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module kepler_eccentric_anomaly_solver import kea_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [27:0] eccentricity, [59:28] mean_anomaly, [91:60] start_estimate
  input  wire logic [95:0]           in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [31:0] eccentric_anomaly, [38:32] iterations_used, [39] overflow
  output logic [39:0]                out_tdata,
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t               cmd;
  dp_status_t            status;
  logic signed [Q_W-1:0] out_est;
  logic                  out_ov;
  logic [ITER_W-1:0]     out_iters;

  kea_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_iters  (out_iters),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .status     (status),
    .cmd        (cmd)
  );

  kea_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .ecc_in    (in_tdata[27:0]),
    .m_in      ($signed(in_tdata[59:28])),
    .est_in    ($signed(in_tdata[91:60])),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .status    (status),
    .out_est   (out_est),
    .out_ov    (out_ov)
  );

  assign out_tdata = {out_ov, out_iters, out_est};

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Kepler equation solver. A directed table walks
// the field extremes and special cases, then random phases run under several
// tolerance and iteration-limit settings with random stalls on both streams.
// A bit-true predictor computes every expected word the table does not give.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import kea_pkg::*;

  localparam longint KQ_ONE    = 64'sd16777216;
  localparam longint KQ_MAX    = 64'sd2147483647;
  localparam longint KQ_MIN    = -64'sd2147483648;
  localparam longint KQ_PI     = 64'sd52707179;
  localparam longint KQ_TWO_PI = 64'sd105414358;
  localparam longint KQ_LN2    = 64'sd11629080;
  localparam longint KQ_HMAX   = 64'sd134217728;
  localparam longint C_PI      = 64'sd3373259426;
  localparam longint C_HALF_PI = 64'sd1686629713;
  localparam longint C_QPI     = 64'sd843314857;
  localparam longint C_CGAIN   = 64'sd652032874;
  localparam longint C_HGAIN   = 64'sd1296540104;
  localparam int     STAGES    = 28;
  localparam int     ITER_CAP  = 64;

  // lowest field last: matches out_tdata packing
  typedef struct packed {
    logic        ovf;
    logic [6:0]  iters;
    logic [31:0] anomaly;
  } solution_t;

  typedef struct {
    logic [27:0] ecc;
    logic [31:0] mean;
    logic [31:0] guess;
    bit          typed;
    solution_t   sol;
  } vector_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_wen = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  solution_t   pending_q[$];
  int          err_cnt = 0;
  int          tx_idle = 0;
  int          rx_idle = 0;
  int          hold_left = 0;
  logic [31:0] tol_reg;
  logic [6:0]  lim_reg;
  longint      atan_lut[STAGES+1];
  longint      atanh_lut[STAGES+1];
  vector_t     vectors[$];

  kepler_eccentric_anomaly_solver u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    #200000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic longint arc_angle(int i, bit hyp);
    longint unsigned acc;
    longint unsigned t;
    int sh;
    acc = 0;
    if (!hyp && i == 0) return C_QPI;
    for (int k = 0; k < 64; k++) begin
      sh = i * (2 * k + 1);
      if (sh > 62) break;
      t = (64'h4000_0000_0000_0000 >> sh) / longint'(2 * k + 1);
      if (hyp || (k % 2) == 0) acc = acc + t;
      else acc = acc - t;
    end
    return longint'((acc + 64'h8000_0000) >> 32);
  endfunction

  function automatic longint clamp_q24(longint v, inout bit ov);
    if (v > KQ_MAX) begin ov = 1; return KQ_MAX; end
    if (v < KQ_MIN) begin ov = 1; return KQ_MIN; end
    return v;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return (a * b) >>> 24;
  endfunction

  function automatic void sin_cos(longint ang, output longint s, output longint c);
    longint r, z, x, y, dx, dy;
    bit flip;
    r = ang % KQ_TWO_PI;
    x = C_CGAIN;
    y = 0;
    flip = 0;
    if (r > KQ_PI) r -= KQ_TWO_PI;
    if (r < -KQ_PI) r += KQ_TWO_PI;
    z = r * 64;
    if (z > C_HALF_PI) begin z = C_PI - z; flip = 1; end
    else if (z < -C_HALF_PI) begin z = -C_PI - z; flip = 1; end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin x -= dx; y += dy; z -= atan_lut[i]; end
      else begin x += dx; y -= dy; z += atan_lut[i]; end
    end
    s = (y + 32) >>> 6;
    c = (x + 32) >>> 6;
    if (flip) c = -c;
  endfunction

  function automatic void sinh_cosh(longint h, output longint sh, output longint ch,
                                    inout bit ov);
    longint a, q, r, z, x, y, dx, dy, ep, em, p, n, sv, cv;
    int i, rep;
    bit again;
    a = (h < 0) ? -h : h;
    x = C_HGAIN;
    y = 0;
    i = 1;
    rep = 4;
    again = 0;
    if (a > KQ_HMAX) a = KQ_HMAX;
    q = (a + KQ_LN2 / 2) / KQ_LN2;
    r = a - q * KQ_LN2;
    z = r * 64;
    for (int st = 0; st < STAGES; st++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin x += dx; y += dy; z -= atanh_lut[i]; end
      else begin x -= dx; y -= dy; z += atanh_lut[i]; end
      // stages 4, 13, 40 ... are repeated for convergence
      if (i == rep && !again) again = 1;
      else begin
        if (i == rep) rep = 3 * rep + 1;
        i++;
        again = 0;
      end
    end
    ep = x + y;
    em = x - y;
    p = ep * (64'sd1 << q);
    n = em / (64'sd1 << q);
    sv = (p - n + 64) >>> 7;
    cv = (p + n + 64) >>> 7;
    if (h < 0) sv = -sv;
    sh = clamp_q24(sv, ov);
    ch = clamp_q24(cv, ov);
  endfunction

  function automatic solution_t solve_kepler(logic [27:0] ecc_in, logic [31:0] m_in,
                                             logic [31:0] g_in);
    solution_t res;
    longint e, m, est, s, c, num, den, delta, mest, d;
    longint unsigned absm, diff;
    int lim, iters;
    bit ov, conv, ell;
    e = longint'(ecc_in);
    m = longint'($signed(m_in));
    est = longint'($signed(g_in));
    absm = (m < 0) ? -m : m;
    lim = lim_reg;
    iters = 0;
    ov = 0;
    conv = 0;
    if (e == 0) begin
      res.anomaly = m_in;
      res.iters = 7'd1;
      res.ovf = 1'b0;
      return res;
    end
    if (e == KQ_ONE) e += 1;
    ell = e < KQ_ONE;
    if (lim == 0) lim = 1;
    if (lim > ITER_CAP) lim = ITER_CAP;
    do begin
      if (ell) begin
        sin_cos(est, s, c);
        num = clamp_q24(est - clamp_q24(fmul(e, s), ov) - m, ov);
        den = clamp_q24(KQ_ONE - clamp_q24(fmul(e, c), ov), ov);
      end else begin
        sinh_cosh(est, s, c, ov);
        num = clamp_q24(clamp_q24(fmul(e, s), ov) - est - m, ov);
        den = clamp_q24(clamp_q24(fmul(e, c), ov) - KQ_ONE, ov);
      end
      if (den == 0) begin
        delta = (num > 0) ? KQ_MAX : ((num < 0) ? KQ_MIN : 0);
        if (num != 0) ov = 1;
      end else begin
        delta = clamp_q24((num * KQ_ONE) / den, ov);
      end
      est = clamp_q24(est - delta, ov);
      if (ell) begin
        sin_cos(est, s, c);
        mest = clamp_q24(est - clamp_q24(fmul(e, s), ov), ov);
      end else begin
        sinh_cosh(est, s, c, ov);
        mest = clamp_q24(clamp_q24(fmul(e, s), ov) - est, ov);
      end
      iters++;
      d = m - mest;
      diff = (d < 0) ? -d : d;
      // shift wraps at 64 bits, as the hardware compare does
      conv = (diff << 32) <= (longint'(tol_reg) * absm);
    end while (iters < lim && !conv);
    if (ell) begin
      est = est % KQ_TWO_PI;
      if (est < 0) est += KQ_TWO_PI;
    end
    res.anomaly = est[31:0];
    res.iters = conv ? iters[6:0] : 7'd0;
    res.ovf = ov;
    return res;
  endfunction

  // ---------------- drivers ----------------
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    if (idx == CFG_REL_TOL) tol_reg = val;
    else lim_reg = val[6:0];
  endtask

  task automatic send_word(vector_t v);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, v.guess, v.mean, v.ecc};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_q.push_back(v.typed ? v.sol : solve_kepler(v.ecc, v.mean, v.guess));
  endtask

  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic vector_t random_vector();
    vector_t v;
    int pick;
    pick = $urandom_range(99);
    v.typed = 0;
    v.sol = '0;
    if (pick < 65) begin
      // elliptic orbit, guess near the mean anomaly
      v.ecc = 28'($urandom_range(1, 32'hFD0000));
      v.mean = $urandom_range(0, 32'd105414357);
      v.guess = v.mean + $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    end else if (pick < 85) begin
      v.ecc = 28'($urandom_range(32'h0100_0000, 32'h0400_0000));
      v.mean = $urandom_range(0, 32'h1400_0000) - 32'h0A00_0000;
      v.guess = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
    end else begin
      v.ecc = 28'($urandom);
      v.mean = $urandom;
      v.guess = $urandom;
    end
    return v;
  endfunction

  task automatic run_phase(int n, int tx_pct, int rx_pct);
    tx_idle = tx_pct;
    rx_idle = rx_pct;
    repeat (n) send_word(random_vector());
    drain_and_settle();
  endtask

  function automatic void add_vec(logic [27:0] e, logic [31:0] m, logic [31:0] g,
                                  bit typed = 0, logic [31:0] xa = 0,
                                  logic [6:0] xi = 0, logic xo = 0);
    vector_t v;
    v.ecc = e;
    v.mean = m;
    v.guess = g;
    v.typed = typed;
    v.sol = '{anomaly: xa, iters: xi, ovf: xo};
    vectors.push_back(v);
  endfunction

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    solution_t got, want;
    if (out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_tdata);
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (got.anomaly !== want.anomaly) begin
          $display("%0t: anomaly exp %h act %h", $time, want.anomaly, got.anomaly);
          err_cnt++;
        end
        if (got.iters !== want.iters) begin
          $display("%0t: iterations exp %0d act %0d", $time, want.iters, got.iters);
          err_cnt++;
        end
        if (got.ovf !== want.ovf) begin
          $display("%0t: overflow exp %b act %b", $time, want.ovf, got.ovf);
          err_cnt++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    for (int i = 0; i <= STAGES; i++) begin
      atan_lut[i] = arc_angle(i, 1'b0);
      atanh_lut[i] = arc_angle(i, 1'b1);
    end
    tol_reg = REL_TOL_RESET;
    lim_reg = ITER_LIMIT_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero eccentricity passes the mean anomaly straight through
    add_vec(28'h0, 32'h0, 32'h0, 1, 32'h0, 7'd1, 1'b0);
    add_vec(28'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h7FFF_FFFF, 7'd1, 1'b0);
    add_vec(28'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h8000_0000, 7'd1, 1'b0);
    add_vec(28'h080_0000, 32'h0, 32'h0);
    add_vec(28'h100_0000, 32'h100_0000, 32'h100_0000);  // e == 1 bumped
    add_vec(28'h100_0000, 32'h0, 32'h0);
    add_vec(28'h100_0001, 32'h0, 32'h0);                // flat derivative
    add_vec(28'hFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_vec(28'hFFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    add_vec(28'h0FF_FFFF, 32'd52707179, 32'd52707179);
    add_vec(28'h000_0001, 32'h1, 32'h0);
    add_vec(28'h080_0000, 32'd105414357, 32'h0);
    add_vec(28'h080_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    add_vec(28'h180_0000, 32'h500_0000, 32'h200_0000);
    add_vec(28'h180_0000, -32'sh500_0000, -32'sh200_0000);
    add_vec(28'h200_0000, 32'h0, 32'h0);
    add_vec(28'h0CC_CCCC, 32'h200_0000, 32'h200_0000);
    add_vec(28'h0CC_CCCC, 32'h200_0000, 32'hFFFF_FFFF);
    add_vec(28'hAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    tx_idle = 6;
    rx_idle = 58;
    foreach (vectors[i]) send_word(vectors[i]);
    drain_and_settle();

    // long receiver stall fills the solver and backs up the input
    hold_left = 3000;
    run_phase(50, 6, 58);

    write_reg(CFG_REL_TOL, 32'h0);
    write_reg(CFG_ITER_LIMIT, 32'd1);
    run_phase(50, 6, 58);

    write_reg(CFG_REL_TOL, 32'hFFFF_FFFF);
    write_reg(CFG_ITER_LIMIT, 32'd64);
    run_phase(50, 58, 6);

    write_reg(CFG_REL_TOL, 32'h0010_0000);
    write_reg(CFG_ITER_LIMIT, 32'd8);
    run_phase(50, 58, 6);

    // out-of-range limits: 0 runs once, 127 runs the cap
    write_reg(CFG_REL_TOL, 32'h0);
    write_reg(CFG_ITER_LIMIT, 32'h7F);
    run_phase(5, 0, 0);
    write_reg(CFG_ITER_LIMIT, 32'h0);
    run_phase(40, 0, 0);

    write_reg(CFG_REL_TOL, $urandom);
    write_reg(CFG_ITER_LIMIT, 32'd4);
    run_phase(50, 0, 0);

    if (err_cnt == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
